[src/thermal_fan_duty_controller_core_defines.svh]
// Assertion helpers for the checker file of the fan duty controller.
`ifndef THERMAL_FAN_DUTY_CONTROLLER_CORE_DEFINES_SVH
`define THERMAL_FAN_DUTY_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/tfdc_pkg.sv]
package tfdc_pkg;

    // Fixed field and register widths.
    localparam int TEMP_W     = 12;
    localparam int DUTY_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NOW_W      = 32;
    localparam int DWELL_W    = 32;

    // Serial divider: the quotient never exceeds the duty span, so 7 bits do.
    localparam int QUOT_W   = DUTY_W;
    localparam int PROD_W   = TEMP_W + DUTY_W;
    localparam int REM_W    = PROD_W + 1;
    localparam int DVS_W    = TEMP_W + QUOT_W - 1;
    localparam int CNT_W    = 3;

    localparam logic [DUTY_W-1:0] DUTY_CAP = 7'd100;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_STATE  = 2'd1,
        CMD_ALERT  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // System states.
    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_SHUTDOWN = 2'd1,
        MODE_RUN      = 2'd2,
        MODE_OTHER    = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_OFF  = 3'd0,
        CFG_TEMP_LOW  = 3'd1,
        CFG_TEMP_HIGH = 3'd2,
        CFG_DUTY_MIN  = 3'd3,
        CFG_DUTY_MAX  = 3'd4,
        CFG_ON_DWELL  = 3'd5,
        CFG_OFF_DWELL = 3'd6
    } t_cfg_idx;

    // What the commit step does with a request.
    typedef enum logic [1:0] {
        ACT_REPORT,
        ACT_FORCE_OFF,
        ACT_UPDATE
    } t_act;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_APPLY
    } t_state;

    // Request payload.
    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [TEMP_W-1:0] temperature;
        logic                     temp_valid;
        logic [NOW_W-1:0]         now_ms;
        logic [1:0]               new_system_state;
        logic                     alert_high_temp;
        logic                     alert_high_humidity;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [DUTY_W-1:0] duty_percent;
        logic              fan_running;
    } t_rsp;

endpackage

[src/thermal_fan_duty_controller_core.sv]
// Flow: a request is taken in S_IDLE, decoded in S_PREP and committed in S_APPLY;
// duty from curve interpolation adds S_MUL and the 7-step serial divider S_DIV.
// One request at a time; S_APPLY waits for a free output register, and the
// next request is taken the cycle after commit.
// Reset (synchronous, active low) restores register defaults, zero duty,
// fan stopped, power-off state and cleared alerts.
module thermal_fan_duty_controller_core
    import tfdc_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_req                  i_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers.
    logic signed [TEMP_W-1:0] r_temp_off;
    logic signed [TEMP_W-1:0] r_temp_low;
    logic signed [TEMP_W-1:0] r_temp_high;
    logic [DUTY_W-1:0]        r_duty_min;
    logic [DUTY_W-1:0]        r_duty_max;
    logic [DWELL_W-1:0]       r_on_dwell;
    logic [DWELL_W-1:0]       r_off_dwell;

    // Controller state.
    t_state                r_state, n_state;
    logic                  r_ovalid, n_ovalid;
    logic [DUTY_W-1:0]     r_cur, n_cur;
    logic                  r_running, n_running;
    logic [TIME_BITS-1:0]  r_last, n_last;
    logic [1:0]            r_mode, n_mode;
    logic                  r_hot, n_hot;
    logic                  r_humid, n_humid;

    // Request and datapath registers.
    t_req                  r_req;
    t_act                  r_act, n_act;
    logic [DUTY_W-1:0]     r_target, n_target;
    logic [TEMP_W-1:0]     r_num, n_num;
    logic [TEMP_W-1:0]     r_span, n_span;
    logic [DUTY_W-1:0]     r_diff, n_diff;
    logic                  r_down, n_down;
    logic [DUTY_W-1:0]     r_base, n_base;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [DVS_W-1:0]      r_dvs, n_dvs;
    logic [QUOT_W-1:0]     r_q, n_q;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    // Combinational helpers.
    logic [DUTY_W-1:0]        w_dmin, w_dmax;
    logic signed [TEMP_W:0]   w_num_s, w_span_s;
    logic [PROD_W-1:0]        w_prod;
    logic [REM_W-1:0]         w_rem_sub;
    logic                     w_fits;
    logic [TIME_BITS-1:0]     w_now;
    logic [TIME_BITS-1:0]     w_elapsed;
    logic                     w_hold;
    logic [DUTY_W-1:0]        w_new_duty;
    logic                     w_commit;

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_ovalid;
    assign o_rsp.duty_percent = r_cur;
    assign o_rsp.fan_running  = r_running;

    // Duty limits clamped to 100 percent.
    assign w_dmin = (r_duty_min > DUTY_CAP) ? DUTY_CAP : r_duty_min;
    assign w_dmax = (r_duty_max > DUTY_CAP) ? DUTY_CAP : r_duty_max;

    // Curve offset and span; both are positive when the curve is used.
    assign w_num_s  = (TEMP_W+1)'(r_req.temperature) - (TEMP_W+1)'(r_temp_low);
    assign w_span_s = (TEMP_W+1)'(r_temp_high) - (TEMP_W+1)'(r_temp_low);

    // Shared multiplier and one restoring divider step.
    assign w_prod    = PROD_W'(r_num) * PROD_W'(r_diff);
    assign w_fits    = (r_rem >= REM_W'(r_dvs));
    assign w_rem_sub = r_rem - REM_W'(r_dvs);

    // Wrapping time since the last on/off toggle.
    assign w_now     = r_req.now_ms[TIME_BITS-1:0];
    assign w_elapsed = w_now - r_last;

    // The output register must be free before new state is committed.
    assign w_commit = !r_ovalid || i_ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_off  <= 12'sd560;
            r_temp_low  <= 12'sd720;
            r_temp_high <= 12'sd1120;
            r_duty_min  <= 7'd30;
            r_duty_max  <= 7'd100;
            r_on_dwell  <= 32'd10000;
            r_off_dwell <= 32'd10000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP_OFF:  r_temp_off  <= i_cfg_wdata[TEMP_W-1:0];
                CFG_TEMP_LOW:  r_temp_low  <= i_cfg_wdata[TEMP_W-1:0];
                CFG_TEMP_HIGH: r_temp_high <= i_cfg_wdata[TEMP_W-1:0];
                CFG_DUTY_MIN:  r_duty_min  <= i_cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:  r_duty_max  <= i_cfg_wdata[DUTY_W-1:0];
                CFG_ON_DWELL:  r_on_dwell  <= i_cfg_wdata[DWELL_W-1:0];
                CFG_OFF_DWELL: r_off_dwell <= i_cfg_wdata[DWELL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_cur     <= '0;
            r_running <= 1'b0;
            r_last    <= '0;
            r_mode    <= MODE_OFF;
            r_hot     <= 1'b0;
            r_humid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_cur     <= n_cur;
            r_running <= n_running;
            r_last    <= n_last;
            r_mode    <= n_mode;
            r_hot     <= n_hot;
            r_humid   <= n_humid;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
        r_act    <= n_act;
        r_target <= n_target;
        r_num    <= n_num;
        r_span   <= n_span;
        r_diff   <= n_diff;
        r_down   <= n_down;
        r_base   <= n_base;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
    end

    // Sequencer: decode, optional multiply and divide, then dwell check and commit.
    always_comb begin
        n_state   = r_state;
        n_ovalid  = r_ovalid;
        n_cur     = r_cur;
        n_running = r_running;
        n_last    = r_last;
        n_mode    = r_mode;
        n_hot     = r_hot;
        n_humid   = r_humid;
        n_act     = r_act;
        n_target  = r_target;
        n_num     = r_num;
        n_span    = r_span;
        n_diff    = r_diff;
        n_down    = r_down;
        n_base    = r_base;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_q       = r_q;
        n_cnt     = r_cnt;
        w_hold     = 1'b0;
        w_new_duty = r_cur;

        // A taken response frees the output register.
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_PREP;
                end
            end

            // Decode the command and pick the target duty where no curve math is needed.
            S_PREP: begin
                n_act   = ACT_REPORT;
                n_state = S_APPLY;
                unique case (r_req.cmd)
                    CMD_UPDATE: begin
                        n_act = ACT_UPDATE;
                        if (r_hot) begin
                            n_target = w_dmax;
                        end else if (r_mode == MODE_OFF || r_mode == MODE_SHUTDOWN) begin
                            n_target = '0;
                        end else if (r_mode == MODE_OTHER) begin
                            n_target = r_humid ? w_dmin : '0;
                        end else if (!r_req.temp_valid) begin
                            n_target = (r_cur != '0) ? w_dmin : '0;
                        end else if (r_req.temperature <= r_temp_off) begin
                            n_target = '0;
                        end else if (r_req.temperature <= r_temp_low) begin
                            n_target = (r_cur != '0) ? w_dmin : '0;
                        end else if (r_req.temperature >= r_temp_high) begin
                            n_target = w_dmax;
                        end else begin
                            // Interpolate between the low and high thresholds.
                            n_num   = w_num_s[TEMP_W-1:0];
                            n_span  = w_span_s[TEMP_W-1:0];
                            n_down  = (w_dmax < w_dmin);
                            n_diff  = (w_dmax >= w_dmin) ? (w_dmax - w_dmin)
                                                         : (w_dmin - w_dmax);
                            n_base  = w_dmin;
                            n_state = S_MUL;
                        end
                    end
                    CMD_STATE: begin
                        n_mode = r_req.new_system_state;
                        if (r_req.new_system_state == MODE_OFF) begin
                            n_act = ACT_FORCE_OFF;
                        end
                    end
                    CMD_ALERT: begin
                        n_hot   = r_req.alert_high_temp;
                        n_humid = r_req.alert_high_humidity;
                    end
                    CMD_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end

            // Product of offset and duty span; a downward curve rounds up.
            S_MUL: begin
                n_rem   = REM_W'(w_prod) + (r_down ? (REM_W'(r_span) - REM_W'(1)) : '0);
                n_dvs   = {r_span, {(QUOT_W-1){1'b0}}};
                n_q     = '0;
                n_cnt   = CNT_W'(QUOT_W - 1);
                n_state = S_DIV;
            end

            // One quotient bit per cycle.
            S_DIV: begin
                n_q   = {r_q[QUOT_W-2:0], w_fits};
                n_dvs = r_dvs >> 1;
                if (w_fits) begin
                    n_rem = w_rem_sub;
                end
                if (r_cnt == '0) begin
                    n_target = r_down ? (r_base - n_q) : (r_base + n_q);
                    n_state  = S_APPLY;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end

            // Dwell check, state update and response.
            S_APPLY: begin
                if (w_commit) begin
                    unique case (r_act)
                        ACT_FORCE_OFF: begin
                            w_new_duty = '0;
                        end
                        ACT_UPDATE: begin
                            if (r_target == '0) begin
                                w_hold = r_running && !r_hot &&
                                         (DWELL_W'(w_elapsed) < r_on_dwell);
                            end else begin
                                w_hold = !r_running && !r_hot &&
                                         (DWELL_W'(w_elapsed) < r_off_dwell);
                            end
                            w_new_duty = w_hold ? r_cur : r_target;
                        end
                        default: begin
                            w_new_duty = r_cur;
                        end
                    endcase
                    if ((r_cur != '0) != (w_new_duty != '0)) begin
                        n_last = w_now;
                    end
                    n_cur     = w_new_duty;
                    n_running = (w_new_duty != '0);
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[src/tfdc_checker.sv]
`include "thermal_fan_duty_controller_core_defines.svh"

module tfdc_checker
    import tfdc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input t_rsp o_rsp
);

    // A stalled response keeps its value.
    `TFDC_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_rsp), "response changed while stalled")

    // The running flag always follows a nonzero duty.
    `TFDC_ASSERT_NOW(a_run_flag, i_clk, i_rst_n, o_valid, o_rsp.fan_running == (o_rsp.duty_percent != '0), "running flag disagrees with duty")

    // Duty never exceeds 100 percent.
    `TFDC_ASSERT_NOW(a_duty_cap, i_clk, i_rst_n, o_valid, o_rsp.duty_percent <= DUTY_CAP, "duty above 100 percent")

    // After taking a request the block is not ready in the following cycle.
    `TFDC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready right after a request")

endmodule

bind thermal_fan_duty_controller_core tfdc_checker u_tfdc_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import tfdc_pkg::*;

    localparam int DRAIN_CYCLES = 16;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_req                  i_req = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Requests waiting to be driven and fan status words still to come back.
    t_req req_backlog[$];
    t_rsp fan_status_due[$];

    int idle_send_pct = 8;
    int stall_recv_pct = 65;
    int mismatches = 0;
    logic [NOW_W-1:0] clock_ms = 32'h0000_1000;

    // Shadow copy of the configuration registers, at their reset values.
    logic signed [TEMP_W-1:0] thr_off = 12'sd560;
    logic signed [TEMP_W-1:0] thr_low = 12'sd720;
    logic signed [TEMP_W-1:0] thr_high = 12'sd1120;
    logic [DUTY_W-1:0]        duty_min_reg = 7'd30;
    logic [DUTY_W-1:0]        duty_max_reg = 7'd100;
    logic [DWELL_W-1:0]       on_dwell = 32'd10000;
    logic [DWELL_W-1:0]       off_dwell = 32'd10000;

    // Shadow copy of the controller state.
    logic [DUTY_W-1:0] fan_duty = '0;
    logic              fan_on = 1'b0;
    logic [NOW_W-1:0]  last_toggle = '0;
    t_mode             sys_mode = MODE_OFF;
    logic              hot_flag = 1'b0;
    logic              humid_flag = 1'b0;

    thermal_fan_duty_controller_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Duty the fan curve asks for, before any dwell check.
    function automatic int fan_curve_duty(logic signed [TEMP_W-1:0] t, logic t_ok);
        int     dlo;
        int     dhi;
        longint span;
        longint num;
        dlo = int'((duty_min_reg > DUTY_CAP) ? DUTY_CAP : duty_min_reg);
        dhi = int'((duty_max_reg > DUTY_CAP) ? DUTY_CAP : duty_max_reg);
        if (hot_flag) return dhi;
        if (sys_mode == MODE_OFF || sys_mode == MODE_SHUTDOWN) return 0;
        if (sys_mode != MODE_RUN) return humid_flag ? dlo : 0;
        if (!t_ok) return (fan_duty != 0) ? dlo : 0;
        if (t <= thr_off) return 0;
        if (t <= thr_low) return (fan_duty != 0) ? dlo : 0;
        if (t >= thr_high) return dhi;
        span = longint'(thr_high) - longint'(thr_low);
        if (span <= 0) return dhi;
        num = longint'(t) - longint'(thr_low);
        if (dhi >= dlo) return dlo + int'((num * (dhi - dlo)) / span);
        // Downward curve: the step is rounded up so the duty stays truncated.
        return dlo - int'((num * (dlo - dhi) + span - 1) / span);
    endfunction

    function automatic void set_duty(int duty, logic [NOW_W-1:0] now);
        logic was_on;
        was_on = (fan_duty != 0);
        fan_duty = (duty > DUTY_CAP) ? DUTY_CAP : duty[DUTY_W-1:0];
        if (was_on != (fan_duty != 0)) last_toggle = now;
        fan_on = (fan_duty != 0);
    endfunction

    // Advance the shadow state by one request and return the status it reports.
    function automatic t_rsp next_fan_status(t_req r);
        t_rsp             rsp;
        int               duty;
        logic [NOW_W-1:0] elapsed;
        case (r.cmd)
            CMD_UPDATE: begin
                duty = fan_curve_duty(r.temperature, r.temp_valid);
                elapsed = r.now_ms - last_toggle;
                if (duty == 0) begin
                    if (!(fan_on && !hot_flag && elapsed < on_dwell)) set_duty(0, r.now_ms);
                end else if (!(!fan_on && !hot_flag && elapsed < off_dwell)) begin
                    set_duty(duty, r.now_ms);
                end
            end
            CMD_STATE: begin
                sys_mode = t_mode'(r.new_system_state);
                if (sys_mode == MODE_OFF) set_duty(0, r.now_ms);
            end
            CMD_ALERT: begin
                hot_flag = r.alert_high_temp;
                humid_flag = r.alert_high_humidity;
            end
            default: ;
        endcase
        rsp.duty_percent = fan_duty;
        rsp.fan_running = fan_on;
        return rsp;
    endfunction

    function automatic int clamp_temp(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic t_req make_req(t_cmd c, int temp, logic t_ok, logic [NOW_W-1:0] now,
                                      t_mode st, logic hot, logic humid);
        t_req r;
        r.cmd = c;
        r.temperature = temp[TEMP_W-1:0];
        r.temp_valid = t_ok;
        r.now_ms = now;
        r.new_system_state = st;
        r.alert_high_temp = hot;
        r.alert_high_humidity = humid;
        return r;
    endfunction

    // Mostly updates around the current thresholds with a time that moves
    // forward, plus state and alert changes and some unused commands.
    function automatic t_req random_req();
        t_req r;
        int   pick;
        int   lo;
        int   hi;
        case ($urandom_range(9))
            0: clock_ms += $urandom();
            1, 2: clock_ms += $urandom_range(20000);
            default: clock_ms += $urandom_range(400);
        endcase
        r.now_ms = clock_ms;
        r.temp_valid = ($urandom_range(9) != 0);
        r.new_system_state = ($urandom_range(99) < 55) ? MODE_RUN : 2'($urandom_range(3));
        r.alert_high_temp = ($urandom_range(99) < 15);
        r.alert_high_humidity = ($urandom_range(99) < 40);
        lo = int'(thr_off);
        if (int'(thr_low) < lo) lo = int'(thr_low);
        if (int'(thr_high) < lo) lo = int'(thr_high);
        hi = int'(thr_off);
        if (int'(thr_low) > hi) hi = int'(thr_low);
        if (int'(thr_high) > hi) hi = int'(thr_high);
        lo = clamp_temp(lo - 64);
        hi = clamp_temp(hi + 64);
        if ($urandom_range(99) < 85) begin
            r.temperature = TEMP_W'(lo + int'($urandom_range(hi - lo)));
        end else begin
            r.temperature = TEMP_W'($urandom());
        end
        pick = $urandom_range(99);
        if (pick < 68) r.cmd = CMD_UPDATE;
        else if (pick < 80) r.cmd = CMD_STATE;
        else if (pick < 94) r.cmd = CMD_ALERT;
        else r.cmd = CMD_NONE;
        return r;
    endfunction

    task automatic queue_req(t_cmd c, int temp, logic t_ok, logic [NOW_W-1:0] now,
                             t_mode st, logic hot, logic humid);
        req_backlog.push_back(make_req(c, temp, t_ok, now, st, hot, humid));
    endtask

    // Block until every request has been answered, then let the pipeline settle.
    // The check runs on the falling edge, after all rising-edge updates have landed.
    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (req_backlog.size() != 0 || fan_status_due.size() != 0 || i_valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_TEMP_OFF:  thr_off = data[TEMP_W-1:0];
            CFG_TEMP_LOW:  thr_low = data[TEMP_W-1:0];
            CFG_TEMP_HIGH: thr_high = data[TEMP_W-1:0];
            CFG_DUTY_MIN:  duty_min_reg = data[DUTY_W-1:0];
            CFG_DUTY_MAX:  duty_max_reg = data[DUTY_W-1:0];
            CFG_ON_DWELL:  on_dwell = data;
            CFG_OFF_DWELL: off_dwell = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(int off, int low, int high, int dmin, int dmax,
                                 logic [DWELL_W-1:0] on_dw, logic [DWELL_W-1:0] off_dw);
        wait_drain();
        write_reg(CFG_TEMP_OFF, off);
        write_reg(CFG_TEMP_LOW, low);
        write_reg(CFG_TEMP_HIGH, high);
        write_reg(CFG_DUTY_MIN, dmin);
        write_reg(CFG_DUTY_MAX, dmax);
        write_reg(CFG_ON_DWELL, on_dw);
        write_reg(CFG_OFF_DWELL, off_dw);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random requests, with the sender holding off halfway until all answers are in.
    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drain();
            req_backlog.push_back(random_req());
        end
    endtask

    // Request driver: valid holds with a stable payload until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                fan_status_due.push_back(next_fan_status(i_req));
            end
            if (!i_valid || o_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= idle_send_pct) begin
                    i_req <= req_backlog.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: each accepted status is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (fan_status_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected response: expected none, got duty %0d running %0b",
                             $time, o_rsp.duty_percent, o_rsp.fan_running);
                end else begin
                    want = fan_status_due.pop_front();
                    if (o_rsp.duty_percent !== want.duty_percent) begin
                        mismatches++;
                        $display("%0t: duty_percent: expected %0d, got %0d",
                                 $time, want.duty_percent, o_rsp.duty_percent);
                    end
                    if (o_rsp.fan_running !== want.fan_running) begin
                        mismatches++;
                        $display("%0t: fan_running: expected %0b, got %0b",
                                 $time, want.fan_running, o_rsp.fan_running);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= stall_recv_pct);
        end
    end

    initial begin : stimulus
        int lo;
        wait (i_rst_n);
        @(posedge i_clk);

        // Default settings: unused command, dwell hold-offs, curve regions, alerts,
        // non-running states, time wrap and a forced stop on power off.
        queue_req(CMD_NONE, 2047, 1'b1, 32'hFFFF_FFFF, MODE_OTHER, 1'b1, 1'b1);
        queue_req(CMD_UPDATE, 900, 1'b1, 32'd1000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_STATE, 0, 1'b0, 32'd2000, MODE_RUN, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 2047, 1'b1, 32'd3000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 2047, 1'b1, 32'd12000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, -2048, 1'b1, 32'd13000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 900, 1'b0, 32'd14000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 640, 1'b1, 32'd15000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 900, 1'b1, 32'd16000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 560, 1'b1, 32'd30000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_ALERT, 0, 1'b0, 32'd31500, MODE_OFF, 1'b1, 1'b0);
        queue_req(CMD_UPDATE, 0, 1'b0, 32'd32000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_ALERT, 0, 1'b0, 32'd32500, MODE_OFF, 1'b0, 1'b1);
        queue_req(CMD_STATE, 0, 1'b0, 32'd33000, MODE_OTHER, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 0, 1'b1, 32'd33500, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_STATE, 0, 1'b0, 32'd34000, MODE_RUN, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 2047, 1'b1, 32'hFFFF_F000, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_STATE, 0, 1'b0, 32'h0000_0100, MODE_OFF, 1'b0, 1'b0);

        // Minimum above maximum with duty registers past the cap: downward curve.
        load_settings(-2048, -2048, 2047, 127, 0, 0, 0);
        queue_req(CMD_STATE, 0, 1'b0, 32'd0, MODE_RUN, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 1024, 1'b1, 32'd1, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, -2047, 1'b1, 32'd2, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 2046, 1'b1, 32'd3, MODE_OFF, 1'b0, 1'b0);

        // Empty curve span with the longest dwells: only the hot alert starts the fan.
        load_settings(-10, 0, 0, 101, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(CMD_STATE, 0, 1'b0, 32'd0, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_STATE, 0, 1'b0, 32'd4, MODE_RUN, 1'b0, 1'b0);
        queue_req(CMD_UPDATE, 5, 1'b1, 32'd5, MODE_OFF, 1'b0, 1'b0);
        queue_req(CMD_ALERT, 0, 1'b0, 32'd6, MODE_OFF, 1'b1, 1'b0);
        queue_req(CMD_UPDATE, 5, 1'b1, 32'd7, MODE_OFF, 1'b0, 1'b0);

        // Random phases under several settings and three idle patterns.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_settings(560, 720, 1120, 30, 100, 2000, 1500);
                1: load_settings(-2048, -2048, 2047, 0, 100, 0, 0);
                2: load_settings(800, 400, 1000, 90, 20, 300, 700);
                3: load_settings(0, 100, 100, 127, 101, 32'hFFFF_FFFF, 0);
                4: load_settings(-500, 0, 2047, 5, 95, 50, 32'hFFFF_FFFF);
                default: begin
                    lo = int'($urandom_range(1800)) - 600;
                    load_settings(clamp_temp(lo - int'($urandom_range(300))), lo,
                                  clamp_temp(lo + int'($urandom_range(800))),
                                  $urandom_range(100), $urandom_range(127),
                                  $urandom_range(2000), $urandom_range(2000));
                end
            endcase
            idle_send_pct = (p < 2) ? 8 : (p < 4) ? 65 : 0;
            stall_recv_pct = (p < 2) ? 65 : (p < 4) ? 8 : 0;
            run_random(316);
        end

        wait_drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
